FILE: rtl/tsfm_pkg.sv
// Shared types and constants for the TCP session flow meter.
package tsfm_pkg;

	// Header and protocol constants
	localparam logic [7:0]  ProtoTcp    = 8'd6;
	localparam int          FlagSynBit  = 1;
	localparam int          FlagFinBit  = 0;
	localparam logic [7:0]  EthHdrBytes = 8'd14;

	// Configuration register map
	localparam int          CfgIdxW = 3;
	localparam logic [CfgIdxW-1:0] RegSrcA = 3'd0;
	localparam logic [CfgIdxW-1:0] RegSrcB = 3'd1;
	localparam logic [CfgIdxW-1:0] RegSrcC = 3'd2;
	localparam logic [CfgIdxW-1:0] RegSrcD = 3'd3;
	localparam logic [CfgIdxW-1:0] RegDst  = 3'd4;

	localparam logic [31:0] RstSrcA = 32'd178835306;
	localparam logic [31:0] RstSrcB = 32'd178835307;
	localparam logic [31:0] RstSrcC = 32'd178835308;
	localparam logic [31:0] RstSrcD = 32'd178835309;
	localparam logic [31:0] RstDst  = 32'd3221963972;

	// Queue between classifier and session engine
	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	// Stream widths
	localparam int InDataW  = 208;
	localparam int OutDataW = 336;

	// Classified packet, as handed from front to back
	typedef struct packed {
		logic [55:0] ts;
		logic [15:0] ip_len;
		logic [15:0] payload;
		logic [31:0] src;
		logic [31:0] dst;
		logic [15:0] sport;
		logic [15:0] dport;
		logic        syn;
		logic        fin;
	} tsfm_entry_t;

	// Closed session record
	typedef struct packed {
		logic [55:0] close_us;
		logic [55:0] open_us;
		logic [31:0] payload_bytes;
		logic [31:0] ip_bytes;
		logic [31:0] packets;
		logic [15:0] dport;
		logic [15:0] sport;
		logic [31:0] dst;
		logic [31:0] src;
		logic [31:0] number;
	} tsfm_record_t;

endpackage

FILE: rtl/tcp_session_flow_meter.sv
// Top level: classifies parsed TCP headers and reports each closed session.
// A closing FIN beat goes into the queue, then is popped into the record register.
// Throughput: one header beat per cycle; the session engine stalls only while a record
// waits on m_axis_tready, and s_axis_tready drops once the four-entry queue is full.
// Reset (arst_n low, asynchronous): queue empty, no session open, session number zero,
// allowed addresses back to their default values.
module tcp_session_flow_meter import tsfm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// Configuration write channel
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [31:0]         cfg_data,
	// Header beats in
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// timestamp_us, captured frame length, ip_header_words, ip_total_length, protocol,
	// source_address, destination_address, TCP source port, TCP destination port,
	// tcp_header_words, tcp_flags
	input  logic [InDataW-1:0]  s_axis_tdata,
	// is_ipv4
	input  logic                s_axis_tuser,
	// Session records out
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// session_number, session_source, session_destination, session source port,
	// session destination port, packet_total, ip_byte_total, payload_byte_total,
	// opening time in us, closing time in us
	output logic [OutDataW-1:0] m_axis_tdata
);

	logic         q_full, q_avail, push, pop;
	tsfm_entry_t  push_entry, pop_entry;
	tsfm_record_t rec;

	assign s_axis_tready = !q_full;

	tsfm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_beat   (s_axis_tvalid && s_axis_tready),
		.is_ipv4   (s_axis_tuser),
		.in_data   (s_axis_tdata),
		.push      (push),
		.entry     (push_entry)
	);

	tsfm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.avail      (q_avail),
		.pop_entry  (pop_entry)
	);

	tsfm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.avail     (q_avail),
		.entry     (pop_entry),
		.pop       (pop),
		.rec_valid (m_axis_tvalid),
		.rec_ready (m_axis_tready),
		.rec       (rec)
	);

	// Pack the record, first field lowest
	assign m_axis_tdata = {rec.close_us, rec.open_us, rec.payload_bytes, rec.ip_bytes,
	                       rec.packets, rec.dport, rec.sport, rec.dst, rec.src, rec.number};

endmodule

FILE: rtl/tsfm_front.sv
// Front end: configuration registers, packet filter and payload length.
module tsfm_front import tsfm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                in_beat,
	input  logic                is_ipv4,
	input  logic [InDataW-1:0]  in_data,
	output logic                push,
	output tsfm_entry_t         entry
);

	logic [31:0] src_a_q, src_b_q, src_c_q, src_d_q, dst_q;
	logic [15:0] cap_len;
	logic [3:0]  ihl, thl;
	logic [7:0]  proto, flags;
	logic [31:0] src, dst;
	logic [7:0]  hdr_len;
	logic [16:0] diff;
	logic        src_ok, keep;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_a_q <= RstSrcA;
			src_b_q <= RstSrcB;
			src_c_q <= RstSrcC;
			src_d_q <= RstSrcD;
			dst_q   <= RstDst;
		end else if (cfg_valid) begin
			case (cfg_index)
				RegSrcA: src_a_q <= cfg_data;
				RegSrcB: src_b_q <= cfg_data;
				RegSrcC: src_c_q <= cfg_data;
				RegSrcD: src_d_q <= cfg_data;
				RegDst:  dst_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Field extraction
	assign cap_len = in_data[71:56];
	assign ihl     = in_data[75:72];
	assign proto   = in_data[99:92];
	assign src     = in_data[131:100];
	assign dst     = in_data[163:132];
	assign thl     = in_data[199:196];
	assign flags   = in_data[207:200];

	// Filter: IPv4, TCP, allowed sender and receiver
	assign src_ok = (src == src_a_q) || (src == src_b_q) ||
	                (src == src_c_q) || (src == src_d_q);
	assign keep   = is_ipv4 && (proto == ProtoTcp) && src_ok && (dst == dst_q);
	assign push   = in_beat && keep;

	// Payload length, clamped at zero
	assign hdr_len = EthHdrBytes + {2'b00, ihl, 2'b00} + {2'b00, thl, 2'b00};
	assign diff    = {1'b0, cap_len} - {9'd0, hdr_len};

	always_comb begin
		entry.ts      = in_data[55:0];
		entry.ip_len  = in_data[91:76];
		entry.payload = diff[16] ? 16'd0 : diff[15:0];
		entry.src     = src;
		entry.dst     = dst;
		entry.sport   = in_data[179:164];
		entry.dport   = in_data[195:180];
		entry.syn     = flags[FlagSynBit];
		entry.fin     = flags[FlagFinBit];
	end

endmodule

FILE: rtl/tsfm_queue.sv
// Short queue of classified packets between front and back.
module tsfm_queue import tsfm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  tsfm_entry_t push_entry,
	output logic        full,
	input  logic        pop,
	output logic        avail,
	output tsfm_entry_t pop_entry
);

	tsfm_entry_t      slot_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCntW-1:0] count_q;

	assign full      = (count_q == QCntW'(QDepth));
	assign avail     = (count_q != '0);
	assign pop_entry = slot_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !avail)) else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCntW'(QDepth)) else $error("queue count out of range");
`endif

endmodule

FILE: rtl/tsfm_back.sv
// Back end: session state, counters and the record output register.
module tsfm_back import tsfm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         avail,
	input  tsfm_entry_t  entry,
	output logic         pop,
	output logic         rec_valid,
	input  logic         rec_ready,
	output tsfm_record_t rec
);

	logic        open_q;
	logic [31:0] sess_cnt_q;
	logic [31:0] ksrc_q, kdst_q;
	logic [15:0] ksport_q, kdport_q;
	logic [55:0] kstart_q;
	logic [31:0] pkt_q, ipb_q, payb_q;
	logic        out_valid_q;
	tsfm_record_t out_q;

	logic        opening, open_now, match, close;
	logic [31:0] sess_n, ksrc_n, kdst_n;
	logic [15:0] ksport_n, kdport_n;
	logic [55:0] kstart_n;
	logic [31:0] pkt_n, ipb_n, payb_n;

	assign pop       = avail && (!out_valid_q || rec_ready);
	assign rec_valid = out_valid_q;
	assign rec       = out_q;

	// Next session state for the packet at the head of the queue
	always_comb begin
		opening  = entry.syn && !open_q;
		open_now = open_q || entry.syn;
		sess_n   = opening ? sess_cnt_q + 32'd1 : sess_cnt_q;
		ksrc_n   = opening ? entry.src   : ksrc_q;
		kdst_n   = opening ? entry.dst   : kdst_q;
		ksport_n = opening ? entry.sport : ksport_q;
		kdport_n = opening ? entry.dport : kdport_q;
		kstart_n = opening ? entry.ts    : kstart_q;
		match    = open_now && (entry.src == ksrc_n) && (entry.dst == kdst_n);
		pkt_n    = match ? pkt_q + 32'd1 : pkt_q;
		ipb_n    = match ? ipb_q + {16'd0, entry.ip_len} : ipb_q;
		payb_n   = match ? payb_q + {16'd0, entry.payload} : payb_q;
		close    = open_now && entry.fin;
	end

	// Session control and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q      <= 1'b0;
			sess_cnt_q  <= '0;
			pkt_q       <= '0;
			ipb_q       <= '0;
			payb_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				sess_cnt_q <= sess_n;
				if (close) begin
					open_q <= 1'b0;
					pkt_q  <= '0;
					ipb_q  <= '0;
					payb_q <= '0;
				end else begin
					open_q <= open_now;
					pkt_q  <= pkt_n;
					ipb_q  <= ipb_n;
					payb_q <= payb_n;
				end
			end
			if (pop && close) begin
				out_valid_q <= 1'b1;
			end else if (rec_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Recorded session fields and the outgoing record
	always_ff @(posedge clk) begin
		if (pop) begin
			ksrc_q   <= ksrc_n;
			kdst_q   <= kdst_n;
			ksport_q <= ksport_n;
			kdport_q <= kdport_n;
			kstart_q <= kstart_n;
		end
		if (pop && close) begin
			out_q.number        <= sess_n;
			out_q.src           <= ksrc_n;
			out_q.dst           <= kdst_n;
			out_q.sport         <= ksport_n;
			out_q.dport         <= kdport_n;
			out_q.packets       <= pkt_n;
			out_q.ip_bytes      <= ipb_n;
			out_q.payload_bytes <= payb_n;
			out_q.open_us       <= kstart_n;
			out_q.close_us      <= entry.ts;
		end
	end

`ifndef SYNTHESIS
	a_close_idles: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && close) |=> !open_q) else $error("session still open after close");
	a_open_counts: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(open_q) |-> sess_cnt_q == $past(sess_cnt_q) + 32'd1)
		else $error("session number not advanced on open");
	a_hold_record: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rec_ready) |-> !pop) else $error("record overwritten");
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!open_q |-> (pkt_q == '0)) else $error("counter not cleared while idle");
`endif

endmodule
